FILE: src/rgql_pkg.sv
// ----------------------------------------------------------------------------
// rgql_pkg
// shared types and constants of the rotated glyph quad layout block
// ----------------------------------------------------------------------------
`default_nettype none

package rgql_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_BEARING = 3'd6;

  // reset values
  localparam logic [15:0]        SCALE_ONE = 16'd256;
  localparam logic signed [15:0] COS_ONE   = 16'sd16384;

  // output range, signed q16.8
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;

  // text width accumulator
  localparam int unsigned WSUM_W = 32;

  typedef struct packed {
    logic [7:0]         char_code;
    logic signed [15:0] bearing_x;
    logic signed [15:0] bearing_y;
    logic [9:0]         glyph_width;
    logic [9:0]         glyph_height;
    logic [15:0]        advance;
    logic               last_glyph;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         quad_char;
    logic signed [23:0] top_right_x;
    logic signed [23:0] top_right_y;
    logic signed [23:0] bottom_right_x;
    logic signed [23:0] bottom_right_y;
    logic signed [23:0] bottom_left_x;
    logic signed [23:0] bottom_left_y;
    logic signed [23:0] top_left_x;
    logic signed [23:0] top_left_y;
    logic               last_quad;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [15:0] reference_bearing_y;
  } cfg_t;

  // stored glyph entries
  typedef struct packed {
    logic [9:0]         glyph_height;
    logic [9:0]         glyph_width;
    logic signed [15:0] bearing_y;
    logic signed [15:0] bearing_x;
  } shape_t;

  typedef struct packed {
    logic [15:0] advance;
    logic [7:0]  char_code;
  } code_adv_t;

  // read issue into the quad pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

  // pipeline status back to the controller
  typedef struct packed {
    logic advance;
    logic busy;
  } pipe_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } emit_state_e;

endpackage

`default_nettype wire

FILE: src/rotated_glyph_quad_layout.sv
// ----------------------------------------------------------------------------
// rotated_glyph_quad_layout
// lays out one line of text as rotated quads, one quad per buffered glyph
// ----------------------------------------------------------------------------
// usage
//   glyph items arrive on the input channel (in_valid_i / in_stall_o), one
//   transfer per cycle while in_stall_o is low, and are written to two glyph
//   memories while their scaled advances are summed into the text width.
//   glyphs beyond MAX_GLYPHS are dropped. the transfer marked last_glyph
//   closes the text. the controller then issues one memory read per cycle
//   while the output is not stalled, in string order, into a six stage quad
//   pipeline; quads leave on the output channel (out_valid_o / out_stall_i)
//   with last_quad on the final one, one quad per cycle while the output is
//   not stalled. the input stays stalled while a text's reads are issued,
//   and a last glyph of the next text is held off until the pipeline has
//   drained. a stalled output freezes the whole pipeline and the memory
//   read port. reset clears control state and loads the configuration
//   defaults; the memories hold no reset and only entries of the current
//   text are read. configuration is written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; the user must write it only while the block is idle, and
//   the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_glyph_quad_layout import rgql_pkg::*; #(
  parameter int unsigned MAX_GLYPHS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_o
);

  localparam int unsigned CW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

  emit_state_e state_q, state_d;

  cfg_t cfg_q, cfg_d;

  logic [CW-1:0]     count_q, count_d;     // glyphs stored for this text
  logic [CW-1:0]     n_q, n_d;             // glyphs to emit
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;   // reads issued
  logic [WSUM_W-1:0] width_sum_q, width_sum_d;
  logic [WSUM_W-1:0] text_width_q, text_width_d;

  logic              in_xfer, has_room, store, text_end;
  logic [25:0]       adv_prod;
  logic [WSUM_W-1:0] sum_next;
  logic [CW-1:0]     count_inc, rd_next;

  issue_t    issue;
  pipe_ctl_t pipe_ctl;
  shape_t    wr_shape, rd_shape;
  code_adv_t wr_code, rd_code;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE_X:     cfg_d.scale_x             = cfg_data_i[15:0];
        CFG_SCALE_Y:     cfg_d.scale_y             = cfg_data_i[15:0];
        CFG_COS_ANGLE:   cfg_d.cos_angle           = $signed(cfg_data_i[15:0]);
        CFG_SIN_ANGLE:   cfg_d.sin_angle           = $signed(cfg_data_i[15:0]);
        CFG_ORIGIN_X:    cfg_d.origin_x            = $signed(cfg_data_i);
        CFG_ORIGIN_Y:    cfg_d.origin_y            = $signed(cfg_data_i);
        CFG_REF_BEARING: cfg_d.reference_bearing_y = $signed(cfg_data_i[15:0]);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- loading
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign has_room  = (count_q != CW'(MAX_GLYPHS));
  assign store     = in_xfer && has_room;
  assign text_end  = in_xfer && in_i.last_glyph;
  assign count_inc = count_q + CW'(1);

  // pen advance is the integer pixel part of the 10.6 advance, scaled
  assign adv_prod = 26'(in_i.advance[15:6]) * 26'(cfg_q.scale_x);
  assign sum_next = width_sum_q + WSUM_W'(adv_prod);

  always_comb begin
    wr_shape.bearing_x    = in_i.bearing_x;
    wr_shape.bearing_y    = in_i.bearing_y;
    wr_shape.glyph_width  = in_i.glyph_width;
    wr_shape.glyph_height = in_i.glyph_height;
    wr_code.char_code     = in_i.char_code;
    wr_code.advance       = in_i.advance;
  end

  // ---------------------------------------------------------------- emission
  assign rd_next = rd_cnt_q + CW'(1);

  always_comb begin
    count_d      = count_q;
    width_sum_d  = width_sum_q;
    text_width_d = text_width_q;
    n_d          = n_q;
    rd_cnt_d     = rd_cnt_q;
    if (text_end) begin
      // snapshot size of the closed text and start over for the next one
      count_d      = '0;
      width_sum_d  = '0;
      text_width_d = store ? sum_next : width_sum_q;
      n_d          = store ? count_inc : count_q;
      rd_cnt_d     = '0;
    end else begin
      if (store) begin
        count_d     = count_inc;
        width_sum_d = sum_next;
      end
      if (issue.valid) begin
        rd_cnt_d = rd_next;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (text_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue.valid && issue.last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall_o  = 1'b0;
    issue.valid = 1'b0;
    issue.last  = (rd_next == n_q);
    case (state_q)
      ST_LOAD: begin
        // a new text may not close while the previous quads still flow
        in_stall_o = in_valid_i && in_i.last_glyph && pipe_ctl.busy;
      end
      ST_EMIT: begin
        in_stall_o  = 1'b1;
        issue.valid = pipe_ctl.advance;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                   <= ST_LOAD;
      cfg_q.scale_x             <= SCALE_ONE;
      cfg_q.scale_y             <= SCALE_ONE;
      cfg_q.cos_angle           <= COS_ONE;
      cfg_q.sin_angle           <= '0;
      cfg_q.origin_x            <= '0;
      cfg_q.origin_y            <= '0;
      cfg_q.reference_bearing_y <= '0;
      count_q                   <= '0;
      width_sum_q               <= '0;
      n_q                       <= '0;
      rd_cnt_q                  <= '0;
      text_width_q              <= '0;
    end else begin
      state_q      <= state_d;
      cfg_q        <= cfg_d;
      count_q      <= count_d;
      width_sum_q  <= width_sum_d;
      n_q          <= n_d;
      rd_cnt_q     <= rd_cnt_d;
      text_width_q <= text_width_d;
    end
  end

  // ---------------------------------------------------------------- storage
  rgql_glyph_ram #(
    .DATA_W ($bits(shape_t)),
    .DEPTH  (MAX_GLYPHS)
  ) u_shape_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_shape),
    .re_i    (pipe_ctl.advance),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rd_shape)
  );

  rgql_glyph_ram #(
    .DATA_W ($bits(code_adv_t)),
    .DEPTH  (MAX_GLYPHS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_code),
    .re_i    (pipe_ctl.advance),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rd_code)
  );

  // ---------------------------------------------------------------- quads
  rgql_quad_pipe u_quad_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .text_width_i (text_width_q),
    .start_i      (text_end),
    .issue_i      (issue),
    .shape_i      (rd_shape),
    .code_i       (rd_code),
    .ctl_o        (pipe_ctl),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

FILE: src/rgql_glyph_ram.sv
// ----------------------------------------------------------------------------
// rgql_glyph_ram
// single port write, single port read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rgql_glyph_ram #(
  parameter int unsigned DATA_W = 52,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds while the consumer is stalled
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/rgql_quad_pipe.sv
// ----------------------------------------------------------------------------
// rgql_quad_pipe
// turns buffered glyph entries into rotated, rounded and saturated quads
// ----------------------------------------------------------------------------
`default_nettype none

module rgql_quad_pipe import rgql_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic [WSUM_W-1:0] text_width_i,
  input  wire logic              start_i,
  input  wire issue_t            issue_i,
  input  wire shape_t            shape_i,
  input  wire code_adv_t         code_i,
  output pipe_ctl_t              ctl_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_o
);

  localparam int unsigned SUM_W   = 56;
  localparam int unsigned REL_W   = 36;
  localparam int unsigned PROD_W  = 52;
  localparam int unsigned SPROD_W = 44;
  localparam int unsigned SIZE_W  = 26;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = 56'sd16384;

  function automatic logic signed [23:0] sat_q8(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-16:0] t;
    logic signed [23:0]       r;
    t = (SUM_W - 15)'(v >>> 15);
    if (t > (SUM_W - 15)'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (t < (SUM_W - 15)'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = 24'(t);
    end
    return r;
  endfunction

  logic advance;

  // text level terms
  logic signed [32:0]      h_q;
  logic signed [SUM_W-1:0] mx_q, my_q;
  logic [WSUM_W-1:0]       pen_q, pen_d;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic last1_q;

  // s2
  logic signed [32:0]     bxs_q, bxs_d;
  logic signed [33:0]     dys_q, dys_d;
  logic signed [16:0]     dy_diff;
  logic [SIZE_W-1:0]      cw_q, cw_d, ch_q, ch_d, adv_prod;
  logic [WSUM_W-1:0]      pen2_q;
  logic [7:0]             char2_q;
  logic                   last2_q;
  logic signed [16:0]     sx_s, sy_s;

  // s3
  logic signed [REL_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [SIZE_W:0]         cw2_q, ch2_q;
  logic [7:0]              char3_q;
  logic                    last3_q;

  // s4
  logic signed [PROD_W-1:0]  crx_q, srx_q, cry_q, sry_q;
  logic signed [SPROD_W-1:0] ccw_q, scw_q, cch_q, sch_q;
  logic signed [SIZE_W+1:0]  cw2_s, ch2_s;
  logic [7:0]                char4_q;
  logic                      last4_q;

  // s5
  logic signed [SUM_W-1:0] base_x_q, base_y_q, ax_q, ay_q, bx_q, by_q;
  logic [7:0]              char5_q;
  logic                    last5_q;

  // corners
  logic signed [SUM_W-1:0] tr_x, tr_y, br_x, br_y, tl_x, tl_y;
  out_item_t               out_q, out_d;

  assign advance = !(out_valid_q && out_stall_i);

  // text level terms, stable before the first entry reaches them
  always_ff @(posedge clk_i) begin
    h_q  <= 33'(cfg_i.reference_bearing_y) * 33'($signed({1'b0, cfg_i.scale_y}));
    mx_q <= (56'(cfg_i.origin_x) <<< 15) + $signed({10'b0, text_width_i, 14'b0}) + ROUND_BIAS;
    my_q <= (56'(cfg_i.origin_y) <<< 15) + (56'(h_q) <<< 14) + ROUND_BIAS;
  end

  // s1: entry from memory
  always_comb begin
    sx_s     = $signed({1'b0, cfg_i.scale_x});
    sy_s     = $signed({1'b0, cfg_i.scale_y});
    bxs_d    = 33'(shape_i.bearing_x) * 33'(sx_s);
    dy_diff  = 17'(cfg_i.reference_bearing_y) - 17'(shape_i.bearing_y);
    dys_d    = 34'(dy_diff) * 34'(sy_s);
    cw_d     = SIZE_W'(shape_i.glyph_width) * SIZE_W'(cfg_i.scale_x);
    ch_d     = SIZE_W'(shape_i.glyph_height) * SIZE_W'(cfg_i.scale_y);
    adv_prod = SIZE_W'(code_i.advance[15:6]) * SIZE_W'(cfg_i.scale_x);
    pen_d    = pen_q;
    if (start_i) begin
      pen_d = '0;
    end else if (advance && v1_q) begin
      pen_d = pen_q + WSUM_W'(adv_prod);
    end
  end

  // s3: glyph rectangle relative to the text center, q.9
  always_comb begin
    rx_d = $signed({3'b0, pen2_q, 1'b0}) - $signed({4'b0, text_width_i})
         + $signed({{2{bxs_q[32]}}, bxs_q, 1'b0});
    ry_d = $signed({dys_q[33], dys_q, 1'b0}) - $signed({{3{h_q[32]}}, h_q});
  end

  assign cw2_s = $signed({1'b0, cw2_q});
  assign ch2_s = $signed({1'b0, ch2_q});

  // corners from base point plus rotated width and height vectors
  always_comb begin
    tr_x = base_x_q + ax_q + bx_q;
    tr_y = base_y_q + ay_q + by_q;
    br_x = base_x_q + ax_q;
    br_y = base_y_q + ay_q;
    tl_x = base_x_q + bx_q;
    tl_y = base_y_q + by_q;
    out_d.quad_char      = char5_q;
    out_d.top_right_x    = sat_q8(tr_x);
    out_d.top_right_y    = sat_q8(tr_y);
    out_d.bottom_right_x = sat_q8(br_x);
    out_d.bottom_right_y = sat_q8(br_y);
    out_d.bottom_left_x  = sat_q8(base_x_q);
    out_d.bottom_left_y  = sat_q8(base_y_q);
    out_d.top_left_x     = sat_q8(tl_x);
    out_d.top_left_y     = sat_q8(tl_y);
    out_d.last_quad      = last5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
      pen_q       <= '0;
    end else begin
      pen_q <= pen_d;
      if (advance) begin
        v1_q        <= issue_i.valid;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        v4_q        <= v3_q;
        v5_q        <= v4_q;
        out_valid_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      last1_q <= issue_i.last;

      bxs_q   <= bxs_d;
      dys_q   <= dys_d;
      cw_q    <= cw_d;
      ch_q    <= ch_d;
      pen2_q  <= pen_q;
      char2_q <= code_i.char_code;
      last2_q <= last1_q;

      rx_q    <= rx_d;
      ry_q    <= ry_d;
      cw2_q   <= {cw_q, 1'b0};
      ch2_q   <= {ch_q, 1'b0};
      char3_q <= char2_q;
      last3_q <= last2_q;

      crx_q   <= PROD_W'(cfg_i.cos_angle) * PROD_W'(rx_q);
      srx_q   <= PROD_W'(cfg_i.sin_angle) * PROD_W'(rx_q);
      cry_q   <= PROD_W'(cfg_i.cos_angle) * PROD_W'(ry_q);
      sry_q   <= PROD_W'(cfg_i.sin_angle) * PROD_W'(ry_q);
      ccw_q   <= SPROD_W'(cfg_i.cos_angle) * SPROD_W'(cw2_s);
      scw_q   <= SPROD_W'(cfg_i.sin_angle) * SPROD_W'(cw2_s);
      cch_q   <= SPROD_W'(cfg_i.cos_angle) * SPROD_W'(ch2_s);
      sch_q   <= SPROD_W'(cfg_i.sin_angle) * SPROD_W'(ch2_s);
      char4_q <= char3_q;
      last4_q <= last3_q;

      base_x_q <= mx_q + SUM_W'(crx_q) + SUM_W'(sry_q);
      base_y_q <= my_q - SUM_W'(srx_q) + SUM_W'(cry_q);
      ax_q     <= SUM_W'(ccw_q);
      ay_q     <= -SUM_W'(scw_q);
      bx_q     <= SUM_W'(sch_q);
      by_q     <= SUM_W'(cch_q);
      char5_q  <= char4_q;
      last5_q  <= last4_q;

      out_q    <= out_d;
    end
  end

  assign ctl_o.advance = advance;
  assign ctl_o.busy    = v1_q | v2_q | v3_q | v4_q | v5_q | out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_o         = out_q;

endmodule

`default_nettype wire
